// File: rtl/core/cspr_pkg.sv
// cspr_pkg: shared types, status codes, register indexes and reset values
// for the checksummed packet receiver core
// no dependencies
`timescale 1ns / 1ps

package cspr_pkg;

   // field widths
   localparam int unsigned ByteW   = 8;
   localparam int unsigned StatusW = 3;
   localparam int unsigned CsrIdxW = 2;

   // frame status codes reported on the result channel
   typedef enum logic [StatusW-1:0] {
      ST_BUSY     = 3'd0,
      ST_ACCEPTED = 3'd1,
      ST_BADSUM   = 3'd2,
      ST_BADHEAD  = 3'd3,
      ST_TOOBIG   = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_PAYLOAD   = 2'd2;

   // configuration reset values
   localparam logic [ByteW-1:0] HEADER_FIRST_RST  = 8'd80;
   localparam logic [ByteW-1:0] HEADER_SECOND_RST = 8'd77;
   localparam logic [ByteW-1:0] MAX_PAYLOAD_RST   = 8'd251;

   // configuration seen by the parser
   typedef struct packed {
      logic [ByteW-1:0] header_first;
      logic [ByteW-1:0] header_second;
      logic [ByteW-1:0] max_payload;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             is_payload;
      logic             frame_end;
      status_type       status;
      logic [ByteW-1:0] component;
   } result_type;

endpackage

// File: rtl/core/cspr_parser.sv
// cspr_parser: frame parse state machine with running checksum and the
// registered result item; depends on cspr_pkg
`timescale 1ns / 1ps

module cspr_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [cspr_pkg::ByteW-1:0]  rx_byte,
   input  cspr_pkg::cfg_type           cfg,
   output cspr_pkg::result_type        result
);

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_SECOND = 3'd1,
      PH_SIZE   = 3'd2,
      PH_CHECK  = 3'd3,
      PH_FIRST  = 3'd4,
      PH_REST   = 3'd5
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [cspr_pkg::ByteW-1:0]  left_ff, left_in;
   logic [cspr_pkg::ByteW-1:0]  sum_ff, sum_in;
   logic [cspr_pkg::ByteW-1:0]  check_ff, check_in;
   logic [cspr_pkg::ByteW-1:0]  first_ff, first_in;
   cspr_pkg::result_type        result_ff, result_in;

   logic [cspr_pkg::ByteW-1:0]  sum_add;
   logic [cspr_pkg::ByteW-1:0]  left_dec;

   assign sum_add  = sum_ff + rx_byte;
   assign left_dec = left_ff - 8'd1;

   // next state and result for the byte in the input register
   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      check_in  = check_ff;
      first_in  = first_ff;
      result_in = '{out_byte: '0, is_payload: 1'b0, frame_end: 1'b0,
                    status: cspr_pkg::ST_BUSY, component: '0};
      unique case (phase_ff)
         PH_SECOND: begin
            if (rx_byte == cfg.header_second) begin
               sum_in   = sum_add;
               phase_in = PH_SIZE;
            end else begin
               result_in.frame_end = 1'b1;
               result_in.status    = cspr_pkg::ST_BADHEAD;
               // a stray first header byte restarts the frame at once
               if (rx_byte == cfg.header_first) begin
                  sum_in   = rx_byte;
                  phase_in = PH_SECOND;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         end
         PH_SIZE: begin
            if (rx_byte > cfg.max_payload) begin
               result_in.frame_end = 1'b1;
               result_in.status    = cspr_pkg::ST_TOOBIG;
               phase_in            = PH_HUNT;
            end else begin
               left_in  = rx_byte;
               sum_in   = sum_add;
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            check_in = rx_byte;
            if (left_ff == '0) begin
               result_in.frame_end = 1'b1;
               result_in.status    = (sum_ff == rx_byte) ? cspr_pkg::ST_EMPTY
                                                         : cspr_pkg::ST_BADSUM;
               phase_in            = PH_HUNT;
            end else begin
               phase_in = PH_FIRST;
            end
         end
         PH_FIRST, PH_REST: begin
            if (phase_ff == PH_FIRST) begin
               first_in = rx_byte;
            end
            result_in.out_byte   = rx_byte;
            result_in.is_payload = 1'b1;
            sum_in               = sum_add;
            left_in              = left_dec;
            if (left_dec == '0) begin
               result_in.frame_end = 1'b1;
               phase_in            = PH_HUNT;
               if (sum_add == check_ff) begin
                  result_in.status    = cspr_pkg::ST_ACCEPTED;
                  result_in.component = (phase_ff == PH_FIRST) ? rx_byte : first_ff;
               end else begin
                  result_in.status = cspr_pkg::ST_BADSUM;
               end
            end else begin
               phase_in = PH_REST;
            end
         end
         default: begin
            // hunting, and any unused phase code
            if (rx_byte == cfg.header_first) begin
               sum_in   = rx_byte;
               phase_in = PH_SECOND;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   // state and result register, advanced once per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         left_ff   <= '0;
         sum_ff    <= '0;
         check_ff  <= '0;
         first_ff  <= '0;
         result_ff <= '{out_byte: '0, is_payload: 1'b0, frame_end: 1'b0,
                        status: cspr_pkg::ST_BUSY, component: '0};
      end else if (step) begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         sum_ff    <= sum_in;
         check_ff  <= check_in;
         first_ff  <= first_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

   // status is only reported on the byte that ends a frame
   assert property (@(posedge clock) disable iff (reset)
      !result_ff.frame_end |-> result_ff.status == cspr_pkg::ST_BUSY)
      else $error("status reported without frame end");

   // component only accompanies an accepted frame
   assert property (@(posedge clock) disable iff (reset)
      result_ff.status != cspr_pkg::ST_ACCEPTED |-> result_ff.component == '0)
      else $error("component given without accepted status");

   // a checksum byte of an empty frame always ends the frame
   assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_CHECK && left_ff == '0 |=>
         result_ff.frame_end && phase_ff == PH_HUNT)
      else $error("empty frame not closed on checksum byte");

   // after a payload byte that ends the frame the parser hunts again
   assert property (@(posedge clock) disable iff (reset)
      step && result_in.is_payload && result_in.frame_end |=> phase_ff == PH_HUNT)
      else $error("parser did not return to hunting after frame end");

endmodule

// File: rtl/core/checksummed_packet_receiver_core.sv
// The result of a request transfer passes through the input register, then the
// parser's result register, before it reaches the result channel. Throughput:
// one byte per cycle while the result channel is not stalled; the parser updates
// its phase and running checksum once per byte.
// Reset: synchronous, active high; parser hunts for the first header byte,
// both channels empty, configuration back to 'P', 'M' and a limit of 251.
`timescale 1ns / 1ps

module checksummed_packet_receiver_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cspr_pkg::ByteW-1:0]    req_rx_byte,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cspr_pkg::ByteW-1:0]    rsp_out_byte,
   output logic                          rsp_is_payload,
   output logic                          rsp_frame_end,
   output logic [cspr_pkg::StatusW-1:0]  rsp_status,
   output logic [cspr_pkg::ByteW-1:0]    rsp_component,
   // configuration write port
   input  logic                          csr_we,
   input  logic [cspr_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [cspr_pkg::ByteW-1:0]    csr_wdata
);

   cspr_pkg::cfg_type           cfg_ff, cfg_in;
   logic                        in_valid_ff, in_valid_in;
   logic [cspr_pkg::ByteW-1:0]  in_byte_ff, in_byte_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        advance;
   logic                        step;
   logic                        req_xfer;
   cspr_pkg::result_type        result;

   // handshake: the result register frees up when empty or taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_byte_in   = req_xfer ? req_rx_byte : in_byte_ff;
      in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            cspr_pkg::CSR_HEADER_FIRST:  cfg_in.header_first  = csr_wdata;
            cspr_pkg::CSR_HEADER_SECOND: cfg_in.header_second = csr_wdata;
            cspr_pkg::CSR_MAX_PAYLOAD:   cfg_in.max_payload   = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{header_first:  cspr_pkg::HEADER_FIRST_RST,
                           header_second: cspr_pkg::HEADER_SECOND_RST,
                           max_payload:   cspr_pkg::MAX_PAYLOAD_RST};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // input byte register, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   cspr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = result.out_byte;
   assign rsp_is_payload = result.is_payload;
   assign rsp_frame_end  = result.frame_end;
   assign rsp_status     = result.status;
   assign rsp_component  = result.component;

   // a held input byte with a stalled result must block new transfers
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request accepted while pipeline is full");

   // a parser step always fills the result register
   assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("parser step lost its result");

   // an untaken result stays pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(result))
      else $error("pending result dropped or changed");

endmodule

// File: test/checksummed_packet_receiver_core_test.sv
// checksummed_packet_receiver_core_test: self-checking bench for the packet receiver core;
// predicts every result transfer from the request bytes and register writes
// depends on cspr_pkg and checksummed_packet_receiver_core
`timescale 1ns / 1ps

// tracks the parser, holds the results still owed and checks each one as it arrives
class frame_scoreboard;
   typedef enum logic [2:0] {
      HUNT_FIRST  = 3'd0,
      WANT_SECOND = 3'd1,
      WANT_SIZE   = 3'd2,
      WANT_CHECK  = 3'd3,
      FIRST_DATA  = 3'd4,
      MORE_DATA   = 3'd5
   } parse_phase_type;

   logic [cspr_pkg::ByteW-1:0] hdr_first;
   logic [cspr_pkg::ByteW-1:0] hdr_second;
   logic [cspr_pkg::ByteW-1:0] size_limit;
   parse_phase_type            phase;
   logic [cspr_pkg::ByteW-1:0] bytes_left;
   logic [cspr_pkg::ByteW-1:0] frame_sum;
   logic [cspr_pkg::ByteW-1:0] rx_check;
   logic [cspr_pkg::ByteW-1:0] first_data;
   cspr_pkg::result_type       owed_q[$];
   int unsigned                fail_count;

   function new();
      hdr_first  = cspr_pkg::HEADER_FIRST_RST;
      hdr_second = cspr_pkg::HEADER_SECOND_RST;
      size_limit = cspr_pkg::MAX_PAYLOAD_RST;
      phase      = HUNT_FIRST;
      bytes_left = '0;
      frame_sum  = '0;
      rx_check   = '0;
      first_data = '0;
      fail_count = 0;
   endfunction

   function void write_reg(logic [cspr_pkg::CsrIdxW-1:0] idx,
                           logic [cspr_pkg::ByteW-1:0] val);
      case (idx)
         cspr_pkg::CSR_HEADER_FIRST:  hdr_first  = val;
         cspr_pkg::CSR_HEADER_SECOND: hdr_second = val;
         cspr_pkg::CSR_MAX_PAYLOAD:   size_limit = val;
         default: ;
      endcase
   endfunction

   // advance the parser by one accepted byte and queue the result it owes
   function void note_byte(logic [cspr_pkg::ByteW-1:0] b);
      cspr_pkg::result_type r;
      r = '0;
      r.status = cspr_pkg::ST_BUSY;
      case (phase)
         WANT_SECOND: begin
            if (b == hdr_second) begin
               frame_sum += b;
               phase = WANT_SIZE;
            end else begin
               r.frame_end = 1'b1;
               r.status = cspr_pkg::ST_BADHEAD;
               // a repeated first header byte opens a fresh frame
               if (b == hdr_first) begin
                  frame_sum = b;
                  phase = WANT_SECOND;
               end else begin
                  phase = HUNT_FIRST;
               end
            end
         end
         WANT_SIZE: begin
            if (b > size_limit) begin
               r.frame_end = 1'b1;
               r.status = cspr_pkg::ST_TOOBIG;
               phase = HUNT_FIRST;
            end else begin
               bytes_left = b;
               frame_sum += b;
               phase = WANT_CHECK;
            end
         end
         WANT_CHECK: begin
            rx_check = b;
            if (bytes_left == 0) begin
               r.frame_end = 1'b1;
               if (frame_sum == rx_check) r.status = cspr_pkg::ST_EMPTY;
               else r.status = cspr_pkg::ST_BADSUM;
               phase = HUNT_FIRST;
            end else begin
               phase = FIRST_DATA;
            end
         end
         FIRST_DATA, MORE_DATA: begin
            if (phase == FIRST_DATA) first_data = b;
            r.out_byte = b;
            r.is_payload = 1'b1;
            frame_sum += b;
            bytes_left -= 1'b1;
            if (bytes_left == 0) begin
               r.frame_end = 1'b1;
               if (frame_sum == rx_check) begin
                  r.status = cspr_pkg::ST_ACCEPTED;
                  r.component = first_data;
               end else begin
                  r.status = cspr_pkg::ST_BADSUM;
               end
               phase = HUNT_FIRST;
            end else begin
               phase = MORE_DATA;
            end
         end
         default: begin
            // hunting: anything but the first header byte is dropped
            if (b == hdr_first) begin
               frame_sum = b;
               phase = WANT_SECOND;
            end else begin
               phase = HUNT_FIRST;
            end
         end
      endcase
      owed_q.push_back(r);
   endfunction

   function void compare_field(string what, logic [cspr_pkg::ByteW-1:0] want,
                               logic [cspr_pkg::ByteW-1:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
         fail_count++;
      end
   endfunction

   function void check_result(cspr_pkg::result_type got);
      cspr_pkg::result_type want;
      if (owed_q.size() == 0) begin
         $display("%0t: result transfer with nothing owed, expected none, actual %p",
                  $time, got);
         fail_count++;
         return;
      end
      want = owed_q.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("is_payload", want.is_payload, got.is_payload);
      compare_field("frame_end", want.frame_end, got.frame_end);
      compare_field("status", want.status, got.status);
      compare_field("component", want.component, got.component);
   endfunction
endclass

module checksummed_packet_receiver_core_test;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [cspr_pkg::ByteW-1:0]    req_rx_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [cspr_pkg::ByteW-1:0]    rsp_out_byte;
   logic                          rsp_is_payload;
   logic                          rsp_frame_end;
   logic [cspr_pkg::StatusW-1:0]  rsp_status;
   logic [cspr_pkg::ByteW-1:0]    rsp_component;
   logic                          csr_we = 1'b0;
   logic [cspr_pkg::CsrIdxW-1:0]  csr_index = '0;
   logic [cspr_pkg::ByteW-1:0]    csr_wdata = '0;

   frame_scoreboard sb = new();
   bit              idle_on = 1'b1;

   checksummed_packet_receiver_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_payload (rsp_is_payload),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_status     (rsp_status),
      .rsp_component  (rsp_component),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // one request transfer, after a random gap when idling is on
   task automatic send_byte(input logic [cspr_pkg::ByteW-1:0] b);
      int gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_byte(b);
   endtask

   // whole frame under the current headers; fill below zero means random payload
   task automatic send_frame(input int unsigned size, input bit good, input int fill);
      logic [cspr_pkg::ByteW-1:0] sum;
      logic [cspr_pkg::ByteW-1:0] chk;
      logic [cspr_pkg::ByteW-1:0] b;
      logic [cspr_pkg::ByteW-1:0] data[$];
      sum = sb.hdr_first + sb.hdr_second + 8'(size);
      for (int i = 0; i < size; i++) begin
         b = (fill < 0) ? 8'($urandom) : 8'(fill);
         data.push_back(b);
         sum += b;
      end
      chk = good ? sum : sum ^ 8'($urandom_range(1, 255));
      send_byte(sb.hdr_first);
      send_byte(sb.hdr_second);
      send_byte(8'(size));
      send_byte(chk);
      foreach (data[i]) send_byte(data[i]);
   endtask

   // stop sending and wait until every owed result has gone out
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [cspr_pkg::CsrIdxW-1:0] idx,
                            input logic [cspr_pkg::ByteW-1:0] val);
      settle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task automatic set_config(input logic [cspr_pkg::ByteW-1:0] hf,
                             input logic [cspr_pkg::ByteW-1:0] hs,
                             input logic [cspr_pkg::ByteW-1:0] lim);
      write_reg(cspr_pkg::CSR_HEADER_FIRST, hf);
      write_reg(cspr_pkg::CSR_HEADER_SECOND, hs);
      write_reg(cspr_pkg::CSR_MAX_PAYLOAD, lim);
   endtask

   // mostly short frames, now and then one up to the limit
   function automatic int unsigned pick_size();
      int unsigned lim;
      lim = sb.size_limit;
      if ($urandom_range(0, 19) == 0) return $urandom_range(0, lim);
      return $urandom_range(0, (lim < 8) ? lim : 8);
   endfunction

   // result side: random stalls, check every transfer
   initial begin : result_sink
      int                   stall;
      cspr_pkg::result_type got;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 11) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         got.out_byte   = rsp_out_byte;
         got.is_payload = rsp_is_payload;
         got.frame_end  = rsp_frame_end;
         got.status     = cspr_pkg::status_type'(rsp_status);
         got.component  = rsp_component;
         sb.check_result(got);
      end
   end

   // stimulus
   initial begin : stimulus
      int unsigned                sent;
      int unsigned                kind;
      int unsigned                n;
      logic [cspr_pkg::ByteW-1:0] b;
      logic [cspr_pkg::ByteW-1:0] hf;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: noise while hunting, empty frames, header and size errors
      send_byte(8'h00);
      send_byte(8'hff);
      send_frame(0, 1'b1, 0);
      send_frame(0, 1'b0, 0);
      send_byte(sb.hdr_first);
      send_byte(8'h12);
      // wrong second header equal to the first one restarts the frame
      send_byte(sb.hdr_first);
      send_frame(1, 1'b1, 8'hff);
      send_byte(sb.hdr_first);
      send_byte(sb.hdr_second);
      send_byte(8'd252);
      // limit changed between the headers and the size byte
      send_byte(sb.hdr_first);
      send_byte(sb.hdr_second);
      write_reg(cspr_pkg::CSR_MAX_PAYLOAD, 8'd0);
      send_byte(8'd1);

      // random phases, each under its own register setting
      for (int p = 0; p < 9; p++) begin
         case (p)
            0: set_config(cspr_pkg::HEADER_FIRST_RST, cspr_pkg::HEADER_SECOND_RST,
                          cspr_pkg::MAX_PAYLOAD_RST);
            1: set_config(8'h00, 8'hff, 8'hff);
            2: set_config(8'hff, 8'h00, 8'h00);
            3: begin
               hf = 8'($urandom);
               set_config(hf, hf, 8'($urandom_range(0, 20)));
            end
            4: set_config(8'($urandom), 8'($urandom), 8'd251);
            default: set_config(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         sent = 0;
         while (sent < 150) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               n = pick_size();
               send_frame(n, $urandom_range(0, 4) != 0, -1);
               sent += n + 4;
            end else if (kind < 78) begin
               do b = 8'($urandom); while (b == sb.hdr_second);
               send_byte(sb.hdr_first);
               send_byte(b);
               sent += 2;
            end else if (kind < 86) begin
               send_byte(sb.hdr_first);
               send_byte(sb.hdr_second);
               sent += 2;
               // oversize where the limit allows, else a frame cut short by what follows
               if (sb.size_limit != 8'hff) begin
                  send_byte(8'($urandom_range(sb.size_limit + 1, 255)));
                  sent += 1;
               end
            end else begin
               n = $urandom_range(1, 4);
               repeat (n) send_byte(8'($urandom));
               sent += n;
            end
            if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/cspr_pkg.sv
rtl/core/cspr_parser.sv
rtl/core/checksummed_packet_receiver_core.sv
test/checksummed_packet_receiver_core_test.sv
